// ===== design/dfa_pkg.sv =====
`default_nettype none

package dfa_pkg;

    localparam int MAX_VECTORS_DEF = 1048576;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DZ_W       = 15;
    localparam int COMP_W     = 16;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 96;

    localparam logic [DZ_W-1:0] DEAD_ZONE_RST = 15'd5;

    typedef enum logic [1:0] {
        SGN_ZERO = 2'b00,
        SGN_NEG  = 2'b01,
        SGN_POS  = 2'b10
    } t_sgn;

    // One classified flow vector as it travels from the front to the back.
    typedef struct packed {
        t_sgn              x_sgn;
        logic [COMP_W-1:0] x_mag;
        t_sgn              y_sgn;
        logic [COMP_W-1:0] y_mag;
        t_sgn              x_dir;
        t_sgn              y_dir;
        logic              last;
    } t_item;

    function automatic t_sgn sign_of(input logic msb, input logic nonzero);
        t_sgn s;
        if (!nonzero) begin
            s = SGN_ZERO;
        end else if (msb) begin
            s = SGN_NEG;
        end else begin
            s = SGN_POS;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/dfa_front.sv =====
`default_nettype none

module dfa_front (
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [dfa_pkg::IN_DATA_W-1:0] i_s_tdata,   // flow_dx, flow_dy
    input  wire logic [dfa_pkg::IN_USER_W-1:0] i_s_tuser,   // movement_x_dir, movement_y_dir
    input  wire logic                          i_s_tlast,   // last_vector
    input  wire logic                          i_q_ready,
    output logic                               o_q_push,
    output dfa_pkg::t_item                     o_q_item
);
    import dfa_pkg::*;

    logic [COMP_W-1:0] w_dx;
    logic [COMP_W-1:0] w_dy;
    logic [1:0]        w_mx;
    logic [1:0]        w_my;

    assign w_dx = i_s_tdata[COMP_W-1:0];
    assign w_dy = i_s_tdata[2*COMP_W-1:COMP_W];
    assign w_mx = i_s_tuser[1:0];
    assign w_my = i_s_tuser[3:2];

    assign o_s_tready = i_q_ready;
    assign o_q_push   = i_s_tvalid && i_q_ready;

    // Negative components travel as magnitudes; the most negative value maps to 0x8000.
    always_comb begin
        o_q_item.x_sgn = sign_of(w_dx[COMP_W-1], |w_dx);
        o_q_item.x_mag = w_dx[COMP_W-1] ? COMP_W'(-w_dx) : w_dx;
        o_q_item.y_sgn = sign_of(w_dy[COMP_W-1], |w_dy);
        o_q_item.y_mag = w_dy[COMP_W-1] ? COMP_W'(-w_dy) : w_dy;
        o_q_item.x_dir = sign_of(w_mx[1], |w_mx);
        o_q_item.y_dir = sign_of(w_my[1], |w_my);
        o_q_item.last  = i_s_tlast;
    end

endmodule

`default_nettype wire

// ===== design/dfa_queue.sv =====
`default_nettype none

module dfa_queue #(
    parameter int DEPTH = dfa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dfa_pkg::t_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    output dfa_pkg::t_item      o_item,
    input  wire logic           i_pop
);
    import dfa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/dfa_div.sv =====
`default_nettype none

module dfa_div #(
    parameter int MAG_W = 36,
    parameter int CNT_W = 21
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MAG_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [MAG_W-1:0]      o_quotient
);
    localparam int STEP_W = $clog2(MAG_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    // Restoring division, one quotient bit per cycle. The partial remainder
    // stays below the divisor, so it fits in the divisor's width.
    assign w_trial = {r_rem, r_quo[MAG_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(MAG_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], w_ge};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/dfa_back.sv =====
`default_nettype none

module dfa_back #(
    parameter int MAX_VECTORS = dfa_pkg::MAX_VECTORS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [dfa_pkg::DZ_W-1:0]       i_dead_zone,
    input  wire logic                           i_q_valid,
    input  wire dfa_pkg::t_item                 i_q_item,
    output logic                                o_q_pop,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [dfa_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import dfa_pkg::*;

    localparam int CNT_W = $clog2(MAX_VECTORS + 1);
    localparam int MAG_W = COMP_W - 1 + CNT_W;
    localparam int NCLS  = 4;

    localparam logic [1:0] CLS_LEFT  = 2'd0;
    localparam logic [1:0] CLS_RIGHT = 2'd1;
    localparam logic [1:0] CLS_UP    = 2'd2;
    localparam logic [1:0] CLS_DOWN  = 2'd3;

    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [MAG_W-1:0]       r_sum [NCLS];
    logic [MAG_W-1:0]       n_sum [NCLS];
    logic [CNT_W-1:0]       r_cnt [NCLS];
    logic [CNT_W-1:0]       n_cnt [NCLS];
    logic [COMP_W-1:0]      r_avg [NCLS];
    logic [1:0]             r_idx;
    logic                   r_launch;
    t_sgn                   r_x_dir;
    t_sgn                   r_y_dir;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic [NCLS-1:0]        w_hit;
    logic [COMP_W-1:0]      w_mag [NCLS];
    logic                   w_div_done;
    logic [MAG_W-1:0]       w_quo;
    logic [COMP_W-1:0]      w_avg;
    logic                   w_clear;
    logic                   w_load;
    logic [COMP_W-1:0]      w_mean_x;
    logic [COMP_W-1:0]      w_mean_y;

    assign o_q_pop    = (r_state == ST_ACC) && i_q_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_hit[CLS_LEFT]  = (i_q_item.x_sgn == SGN_NEG);
    assign w_hit[CLS_RIGHT] = (i_q_item.x_sgn == SGN_POS);
    assign w_hit[CLS_UP]    = (i_q_item.y_sgn == SGN_NEG);
    assign w_hit[CLS_DOWN]  = (i_q_item.y_sgn == SGN_POS);
    assign w_mag[CLS_LEFT]  = i_q_item.x_mag;
    assign w_mag[CLS_RIGHT] = i_q_item.x_mag;
    assign w_mag[CLS_UP]    = i_q_item.y_mag;
    assign w_mag[CLS_DOWN]  = i_q_item.y_mag;

    dfa_div #(
        .MAG_W (MAG_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_launch),
        .i_dividend (r_sum[r_idx]),
        .i_divisor  (r_cnt[r_idx]),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Quotient magnitudes never exceed 0x8000, so the low bits hold them.
    // An empty class or a result inside the dead zone reads as zero.
    always_comb begin
        w_avg = w_quo[COMP_W-1:0];
        if (r_cnt[r_idx] == '0 || w_avg < {1'b0, i_dead_zone}) begin
            w_avg = '0;
        end
    end

    assign w_clear = w_div_done && (r_idx == CLS_DOWN);
    assign w_load  = (r_state == ST_EMIT) && (!r_out_valid || i_m_tready);

    always_comb begin
        for (int c = 0; c < NCLS; c++) begin
            n_sum[c] = r_sum[c];
            n_cnt[c] = r_cnt[c];
            if (w_clear) begin
                n_sum[c] = '0;
                n_cnt[c] = '0;
            end else if (o_q_pop && w_hit[c] && r_cnt[c] != CNT_W'(MAX_VECTORS)) begin
                n_sum[c] = r_sum[c] + MAG_W'(w_mag[c]);
                n_cnt[c] = r_cnt[c] + 1'b1;
            end
        end
    end

    // Negative averages are kept as magnitudes and negated on the way out.
    function automatic logic [COMP_W-1:0] choose(input t_sgn dir,
                                                 input logic [COMP_W-1:0] neg_mag,
                                                 input logic [COMP_W-1:0] pos_val);
        logic [COMP_W-1:0] neg_val;
        logic [COMP_W-1:0] pick;
        neg_val = COMP_W'(-neg_mag);
        unique case (dir)
            SGN_POS:  pick = (pos_val != '0) ? pos_val : neg_val;
            SGN_NEG:  pick = (neg_mag != '0) ? neg_val : pos_val;
            default:  pick = (neg_mag > pos_val) ? neg_val : pos_val;
        endcase
        return pick;
    endfunction

    assign w_mean_x = choose(r_x_dir, r_avg[CLS_LEFT], r_avg[CLS_RIGHT]);
    assign w_mean_y = choose(r_y_dir, r_avg[CLS_UP], r_avg[CLS_DOWN]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC: begin
                if (o_q_pop && i_q_item.last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_clear) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_launch    <= 1'b0;
            r_idx       <= CLS_LEFT;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NCLS; c++) begin
                r_sum[c] <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_launch <= 1'b0;
            for (int c = 0; c < NCLS; c++) begin
                r_sum[c] <= n_sum[c];
                r_cnt[c] <= n_cnt[c];
            end
            if (o_q_pop && i_q_item.last) begin
                r_idx    <= CLS_LEFT;
                r_launch <= 1'b1;
            end else if (w_div_done && !w_clear) begin
                r_idx    <= r_idx + 1'b1;
                r_launch <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.last) begin
            r_x_dir <= i_q_item.x_dir;
            r_y_dir <= i_q_item.y_dir;
        end
        if (w_div_done) begin
            r_avg[r_idx] <= w_avg;
        end
        if (w_load) begin
            r_out_data <= {2'b00,
                           r_avg[CLS_DOWN][COMP_W-2:0],
                           COMP_W'(-r_avg[CLS_UP]),
                           r_avg[CLS_RIGHT][COMP_W-2:0],
                           COMP_W'(-r_avg[CLS_LEFT]),
                           w_mean_y,
                           w_mean_x};
        end
    end

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_done || r_launch) |-> (r_state == ST_DIV))
        else $error("divider active outside the divide phase");

    a_store_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt[CLS_LEFT] == '0 && r_cnt[CLS_RIGHT] == '0 &&
                                  r_cnt[CLS_UP] == '0 && r_cnt[CLS_DOWN] == '0))
        else $error("store not cleared before result is emitted");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[CLS_LEFT] <= CNT_W'(MAX_VECTORS)) && (r_cnt[CLS_RIGHT] <= CNT_W'(MAX_VECTORS))
        && (r_cnt[CLS_UP] <= CNT_W'(MAX_VECTORS)) && (r_cnt[CLS_DOWN] <= CNT_W'(MAX_VECTORS)))
        else $error("class count passed its limit");

    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == ST_ACC))
        else $error("result loaded without returning to accumulation");

endmodule

`default_nettype wire

// ===== design/directional_flow_aggregator.sv =====
`default_nettype none

// Directional flow aggregator. Each input item is one signed Q8.8 flow vector; the block
// sums negative and positive components per axis and, on the item marked with tlast,
// outputs the truncated averages after the dead zone together with one mean per axis
// chosen from the previous movement direction carried in tuser. While a frame is being
// collected the block takes one item per cycle; a four-entry queue sits between the
// input and the accumulators. After the last item the four averages come from one
// shared restoring divider, one quotient bit per cycle over a MAG_W-bit dividend, where
// MAG_W = 15 + clog2(MAX_VECTORS + 1) (36 at the default); items arriving during the
// division and the output handshake wait in the queue.
// The dead zone register may only be written while no frame is in flight.
module directional_flow_aggregator #(
    parameter int MAX_VECTORS = dfa_pkg::MAX_VECTORS_DEF,
    parameter int QUEUE_DEPTH = dfa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [dfa_pkg::DZ_W-1:0]       i_cfg_wr_data,    // dead_zone
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [dfa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,   // flow_dx, flow_dy
    input  wire logic [dfa_pkg::IN_USER_W-1:0]  i_s_axis_tuser,   // movement_x_dir, movement_y_dir
    input  wire logic                           i_s_axis_tlast,   // last_vector
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // mean_x, mean_y, left_avg, right_avg, up_avg, down_avg, two zero bits
    output logic [dfa_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);
    import dfa_pkg::*;

    logic [DZ_W-1:0] r_dead_zone;
    logic            w_q_ready;
    logic            w_q_push;
    t_item           w_front_item;
    logic            w_q_valid;
    t_item           w_q_item;
    logic            w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DEAD_ZONE_RST;
        end else if (i_cfg_wr_en) begin
            r_dead_zone <= i_cfg_wr_data;
        end
    end

    dfa_front u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_s_tlast  (i_s_axis_tlast),
        .i_q_ready  (w_q_ready),
        .o_q_push   (w_q_push),
        .o_q_item   (w_front_item)
    );

    dfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    dfa_back #(
        .MAX_VECTORS (MAX_VECTORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dead_zone (r_dead_zone),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/directional_flow_aggregator_tb.sv =====
`default_nettype none

module directional_flow_aggregator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfa_pkg::*;

    localparam int  DRAIN_CYCLES = 200;
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  PHASE_ITEMS  = 215;

    typedef struct {
        logic signed [COMP_W-1:0] dx;
        logic signed [COMP_W-1:0] dy;
        logic [1:0]               mx;
        logic [1:0]               my;
        logic                     last;
    } t_flow_vec;

    // Same layout as the master tdata, highest field first.
    typedef struct packed {
        logic [1:0]  pad;
        logic [14:0] down_avg;
        logic [15:0] up_avg;
        logic [14:0] right_avg;
        logic [15:0] left_avg;
        logic [15:0] mean_y;
        logic [15:0] mean_x;
    } t_frame_mean;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [DZ_W-1:0]       cfg_wr_data   = '0;
    logic                  s_tvalid      = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata       = '0;
    logic [IN_USER_W-1:0]  s_tuser       = '0;
    logic                  s_tlast       = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready      = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    t_flow_vec   vec_backlog[$];
    t_frame_mean expected_means[$];

    int          n_queued    = 0;
    int          n_accepted  = 0;
    int          errors      = 0;
    int          cycles      = 0;
    int          tx_idle_pct = 33;
    int          rx_idle_pct = 61;
    bit          s_fire      = 1'b0;
    bit          s_fire_last = 1'b0;
    bit          drain_hold  = 1'b0;

    // Shadow of the block's state.
    int unsigned dz_shadow = 32'(DEAD_ZONE_RST);
    longint      sum_left, sum_right, sum_up, sum_down;
    int unsigned cnt_left, cnt_right, cnt_up, cnt_down;

    directional_flow_aggregator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint class_mean(input longint total, input int unsigned n);
        longint a;
        longint mag;
        if (n == 0) begin
            return 0;
        end
        // SystemVerilog division truncates toward zero.
        a   = total / longint'(n);
        mag = (a < 0) ? -a : a;
        if (mag < longint'(dz_shadow)) begin
            a = 0;
        end
        return a;
    endfunction

    function automatic longint pick_mean(input logic [1:0] dir, input longint neg,
                                         input longint pos);
        logic signed [1:0] sd;
        sd = dir;
        if (sd > 0) begin
            return (pos > 0) ? pos : neg;
        end else if (sd < 0) begin
            return (neg < 0) ? neg : pos;
        end
        return (-neg > pos) ? neg : pos;
    endfunction

    task automatic add_component(inout longint nsum, inout int unsigned ncnt,
                                 inout longint psum, inout int unsigned pcnt,
                                 input logic signed [COMP_W-1:0] c);
        if (c < 0) begin
            if (ncnt < MAX_VECTORS_DEF) begin
                nsum += c;
                ncnt++;
            end
        end else if (c > 0) begin
            if (pcnt < MAX_VECTORS_DEF) begin
                psum += c;
                pcnt++;
            end
        end
    endtask

    task automatic fold_vector(input t_flow_vec v);
        longint      la, ra, ua, da, cx, cy;
        t_frame_mean m;
        add_component(sum_left, cnt_left, sum_right, cnt_right, v.dx);
        add_component(sum_up, cnt_up, sum_down, cnt_down, v.dy);
        if (v.last) begin
            la = class_mean(sum_left, cnt_left);
            ra = class_mean(sum_right, cnt_right);
            ua = class_mean(sum_up, cnt_up);
            da = class_mean(sum_down, cnt_down);
            cx = pick_mean(v.mx, la, ra);
            cy = pick_mean(v.my, ua, da);
            m.pad       = '0;
            m.mean_x    = cx[15:0];
            m.mean_y    = cy[15:0];
            m.left_avg  = la[15:0];
            m.right_avg = ra[14:0];
            m.up_avg    = ua[15:0];
            m.down_avg  = da[14:0];
            expected_means = {expected_means, m};
            sum_left = 0;
            sum_right = 0;
            sum_up = 0;
            sum_down = 0;
            cnt_left = 0;
            cnt_right = 0;
            cnt_up = 0;
            cnt_down = 0;
        end
    endtask

    function automatic string fmt_mean(input t_frame_mean m);
        return $sformatf("mx=%0d my=%0d l=%0d r=%0d u=%0d d=%0d pad=%b",
                         $signed(m.mean_x), $signed(m.mean_y), $signed(m.left_avg),
                         m.right_avg, $signed(m.up_avg), m.down_avg, m.pad);
    endfunction

    task automatic note_error(input string msg);
        if (errors < 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
        errors++;
    endtask

    // Sampling side: predictor on accepted inputs, comparison on accepted results.
    always @(posedge i_clk) begin
        t_flow_vec   v;
        t_frame_mean got;
        t_frame_mean want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            if (cfg_wr_en) begin
                dz_shadow = 32'(cfg_wr_data);
            end
            s_fire = 1'b0;
            if ((s_tvalid && s_tready) === 1'b1) begin
                v.dx   = s_tdata[15:0];
                v.dy   = s_tdata[31:16];
                v.mx   = s_tuser[1:0];
                v.my   = s_tuser[3:2];
                v.last = s_tlast;
                fold_vector(v);
                n_accepted++;
                s_fire      = 1'b1;
                s_fire_last = s_tlast;
            end
            if ((m_tvalid && m_tready) === 1'b1) begin
                got = m_tdata;
                if (expected_means.size() == 0) begin
                    note_error({"unexpected result: ", fmt_mean(got)});
                end else begin
                    want = expected_means.pop_front();
                    if (got !== want) begin
                        note_error({"mismatch exp ", fmt_mean(want), " got ", fmt_mean(got)});
                    end
                end
            end
        end
    end

    // Driving side: sender and receiver change at the falling edge.
    always @(negedge i_clk) begin
        t_flow_vec            v;
        logic                 nvalid;
        logic [IN_DATA_W-1:0] ndata;
        logic [IN_USER_W-1:0] nuser;
        logic                 nlast;
        nvalid = s_tvalid;
        ndata  = s_tdata;
        nuser  = s_tuser;
        nlast  = s_tlast;
        if (s_fire && s_fire_last && $urandom_range(0, 5) == 0) begin
            drain_hold = 1'b1;
        end
        if (!s_tvalid || s_fire) begin
            if (drain_hold && expected_means.size() != 0) begin
                nvalid = 1'b0;
            end else begin
                drain_hold = 1'b0;
                if (vec_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    v      = vec_backlog.pop_front();
                    nvalid = 1'b1;
                    ndata  = {v.dy, v.dx};
                    nuser  = {v.my, v.mx};
                    nlast  = v.last;
                end else begin
                    nvalid = 1'b0;
                end
            end
        end
        s_tvalid <= nvalid;
        s_tdata  <= ndata;
        s_tuser  <= nuser;
        s_tlast  <= nlast;
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic queue_vec(input int dx, input int dy, input logic [1:0] mx,
                             input logic [1:0] my, input logic last);
        t_flow_vec v;
        v.dx   = dx[15:0];
        v.dy   = dy[15:0];
        v.mx   = mx;
        v.my   = my;
        v.last = last;
        vec_backlog = {vec_backlog, v};
        n_queued++;
    endtask

    function automatic int rand_comp();
        logic [31:0] bits;
        bits = $urandom();
        case ($urandom_range(0, 9))
            0, 1: begin
                return 0;
            end
            2, 3, 4: begin
                return int'($urandom_range(0, 80)) - 40;
            end
            5, 6, 7: begin
                return int'($signed(bits[15:0]));
            end
            8: begin
                return bits[16] ? 32767 : -32768;
            end
            default: begin
                return int'($urandom_range(0, 4000)) - 2000;
            end
        endcase
    endfunction

    task automatic gen_frame(inout int count);
        int len;
        int r;
        bit quiet;
        r     = $urandom_range(0, 99);
        len   = (r < 10) ? 1 : (r < 90) ? $urandom_range(2, 16) : $urandom_range(17, 64);
        quiet = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < len; i++) begin
            queue_vec(quiet ? 0 : rand_comp(), quiet ? 0 : rand_comp(),
                      2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), i == len - 1);
        end
        count += len;
    endtask

    // Waits until every item is in and every result is out, then lets the divider settle.
    task automatic wait_drain();
        do begin
            @(negedge i_clk);
        end while (n_accepted != n_queued || expected_means.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_dead_zone(input int unsigned value);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[DZ_W-1:0];
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int count;
        sum_left = 0;
        sum_right = 0;
        sum_up = 0;
        sum_down = 0;
        cnt_left = 0;
        cnt_right = 0;
        cnt_up = 0;
        cnt_down = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Last item with nothing accumulated.
        queue_vec(0, 0, 2'b00, 2'b00, 1'b1);
        // Extremes of both components.
        queue_vec(-32768, 32767, 2'b01, 2'b01, 1'b1);
        queue_vec(32767, -32768, 2'b11, 2'b11, 1'b1);
        // Truncation toward zero, the -2 direction code, and averages inside the dead zone.
        queue_vec(-7, 4, 2'b00, 2'b00, 1'b0);
        queue_vec(-8, 4, 2'b00, 2'b00, 1'b0);
        queue_vec(10, -3, 2'b10, 2'b00, 1'b1);
        // Magnitudes exactly at the dead zone are kept.
        queue_vec(5, -5, 2'b00, 2'b00, 1'b1);
        // Equal magnitudes with no movement pick the positive side.
        queue_vec(-9, 9, 2'b00, 2'b00, 1'b0);
        queue_vec(9, -9, 2'b00, 2'b00, 1'b1);
        // Both classes filled, every direction code on both axes.
        for (int d = 0; d < 4; d++) begin
            queue_vec(-20, 30, 2'b00, 2'b00, 1'b0);
            queue_vec(40, -50, d[1:0], 2'(3 - d), 1'b1);
        end
        // Zeros before a single nonzero vector.
        queue_vec(0, 0, 2'b01, 2'b11, 1'b0);
        queue_vec(0, 0, 2'b01, 2'b11, 1'b0);
        queue_vec(-300, 700, 2'b01, 2'b11, 1'b1);
        wait_drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    tx_idle_pct = 33;
                    rx_idle_pct = 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct = 33;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (phase)
                0: write_dead_zone(0);
                1: write_dead_zone(32767);
                2: write_dead_zone($urandom_range(0, 32767));
                3: write_dead_zone(1);
                4: write_dead_zone($urandom_range(0, 64));
                default: write_dead_zone(5);
            endcase
            count = 0;
            while (count < PHASE_ITEMS) begin
                gen_frame(count);
            end
            wait_drain();
        end

        if (errors == 0 && expected_means.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
